// ===== rtl/alw_pkg.sv =====
// Package for the anti-aliased line walker: beat types, controller/datapath
// command and status structs, and fixed widths and codes.
// Depends on nothing; every other file of the block imports it.
package alw_pkg;

    localparam int COORD_BITS = 12;
    localparam int DIM_W      = 11;
    localparam int ADDR_W     = 20;
    localparam int SHADE_W    = 8;
    localparam int CFG_IDX_W  = 1;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_HEIGHT = 1'b1;

    localparam logic [DIM_W-1:0] BUFFER_WIDTH_RESET  = 11'd384;
    localparam logic [DIM_W-1:0] BUFFER_HEIGHT_RESET = 11'd256;

    typedef struct packed {
        logic                          cmd;
        logic signed [COORD_BITS-1:0]  start_x;
        logic signed [COORD_BITS-1:0]  start_y;
        logic signed [COORD_BITS-1:0]  end_x;
        logic signed [COORD_BITS-1:0]  end_y;
        logic [3:0]                    shade_shift;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic               far_is_below;
        logic [SHADE_W-1:0] near_shade;
        logic [SHADE_W-1:0] far_shade;
        logic               write_enable;
        logic               last;
    } out_beat_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic div_done;
        logic emit;
    } alw_cmd_t;

    typedef struct packed {
        logic degenerate;
        logic line_active;
    } alw_status_t;

endpackage

// ===== rtl/alw_controller.sv =====
// Controller of the line walker: handshake control, divide sequencing and
// the output valid flag. Depends on alw_pkg; drives alw_datapath commands.
module alw_controller
    import alw_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        in_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    input  alw_status_t status,
    output alw_cmd_t    cmd
);

    localparam int CNT_W = $clog2(FRACTION_BITS + 1);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_DIVIDE = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             count_last;

    assign in_ready   = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept     = in_valid && in_ready;
    assign count_last = (count_reg == CNT_W'(FRACTION_BITS));
    assign out_valid  = out_valid_reg;

    always_comb
    begin
        cmd.load     = accept && (in_cmd == CMD_START);
        cmd.emit     = accept && (in_cmd == CMD_STEP) && status.line_active;
        cmd.div_step = (state_reg == ST_DIVIDE);
        cmd.div_done = (state_reg == ST_DIVIDE) && count_last;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load && !status.degenerate)
                begin
                    state_next = ST_DIVIDE;
                    count_next = '0;
                end
            end
            ST_DIVIDE:
            begin
                count_next = count_reg + CNT_W'(1);
                if (count_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== rtl/alw_datapath.sv =====
// Datapath of the line walker: buffer size registers, endpoint ordering,
// restoring slope divider, minor-axis accumulator and pixel beat register.
// Depends on alw_pkg; sequenced by alw_controller.
module alw_datapath
    import alw_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  in_beat_t             in_data,
    input  alw_cmd_t             cmd,
    output alw_status_t          status,
    output out_beat_t            out_data
);

    localparam int MAG_W   = COORD_BITS + 1;
    localparam int REM_W   = COORD_BITS + 2;
    localparam int Q_W     = FRACTION_BITS + 1;
    localparam int SLOPE_W = FRACTION_BITS + 2;
    localparam int ACC_W   = COORD_BITS + FRACTION_BITS + 2;
    localparam int MIN_W   = ACC_W - FRACTION_BITS;
    localparam int CMP_W   = (MIN_W + 1 > DIM_W + 2) ? MIN_W + 1 : DIM_W + 2;
    localparam int SH_W    = (FRACTION_BITS > SHADE_W) ? FRACTION_BITS : SHADE_W;
    localparam int PROD_W  = 2 * DIM_W;

    logic [DIM_W-1:0]             width_reg, width_next;
    logic [DIM_W-1:0]             height_reg, height_next;
    logic                         active_reg, active_next;
    logic                         x_major_reg, x_major_next;
    logic signed [COORD_BITS-1:0] pos_reg, pos_next;
    logic signed [COORD_BITS-1:0] end_reg, end_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [SLOPE_W-1:0]    slope_reg, slope_next;
    logic [3:0]                   shift_reg, shift_next;
    logic [MAG_W-1:0]             divisor_reg, divisor_next;
    logic [REM_W-1:0]             rem_reg, rem_next;
    logic [Q_W-1:0]               quo_reg, quo_next;
    logic                         neg_reg, neg_next;
    out_beat_t                    out_reg, out_next;

    logic signed [MAG_W-1:0]      dx, dy;
    logic [MAG_W-1:0]             adx, ady;
    logic                         x_major_in;
    logic                         swap;
    logic signed [COORD_BITS-1:0] major_lo, major_hi, minor_start;

    logic                         ge;
    logic [REM_W-1:0]             rem_sub;
    logic [Q_W-1:0]               quo_shift;
    logic signed [SLOPE_W-1:0]    slope_pos;

    logic signed [MIN_W-1:0]      minor;
    logic [FRACTION_BITS-1:0]     frac;
    logic signed [CMP_W-1:0]      row_c, col_c, w_c, h_c;
    logic                         en;
    logic [PROD_W-1:0]            addr_full;
    logic [SH_W-1:0]              near_raw, far_raw;
    logic signed [COORD_BITS-1:0] pos_plus;
    logic                         is_last;
    out_beat_t                    beat;

    always_comb
    begin
        dx = MAG_W'(in_data.end_x) - MAG_W'(in_data.start_x);
        dy = MAG_W'(in_data.end_y) - MAG_W'(in_data.start_y);
        adx = dx[MAG_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
        ady = dy[MAG_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
        x_major_in = (ady < adx);
        if (x_major_in)
        begin
            swap        = (in_data.start_x > in_data.end_x);
            major_lo    = swap ? in_data.end_x : in_data.start_x;
            major_hi    = swap ? in_data.start_x : in_data.end_x;
            minor_start = swap ? in_data.end_y : in_data.start_y;
        end
        else
        begin
            swap        = (in_data.start_y > in_data.end_y);
            major_lo    = swap ? in_data.end_y : in_data.start_y;
            major_hi    = swap ? in_data.start_y : in_data.end_y;
            minor_start = swap ? in_data.end_x : in_data.start_x;
        end
    end

    assign status.degenerate  = (dx == '0) && (dy == '0);
    assign status.line_active = active_reg;

    always_comb
    begin
        ge        = (rem_reg >= REM_W'(divisor_reg));
        rem_sub   = ge ? (rem_reg - REM_W'(divisor_reg)) : rem_reg;
        quo_shift = {quo_reg[Q_W-2:0], ge};
        slope_pos = SLOPE_W'(quo_shift);
    end

    always_comb
    begin
        minor    = acc_reg[ACC_W-1:FRACTION_BITS];
        frac     = acc_reg[FRACTION_BITS-1:0];
        w_c      = CMP_W'(width_reg);
        h_c      = CMP_W'(height_reg);
        pos_plus = pos_reg + COORD_BITS'(1);
        is_last  = (pos_plus == end_reg);
        if (x_major_reg)
        begin
            col_c = CMP_W'(pos_reg);
            row_c = CMP_W'(minor);
            en    = (col_c >= 0) && (col_c < w_c) && (row_c >= 0) && (row_c < h_c - 1);
        end
        else
        begin
            row_c = CMP_W'(pos_reg);
            col_c = CMP_W'(minor);
            en    = (row_c >= 0) && (row_c < h_c) && (col_c >= 0) && (col_c < w_c - 1);
        end
        addr_full = PROD_W'(row_c[DIM_W-1:0]) * PROD_W'(width_reg)
                    + PROD_W'(col_c[DIM_W-1:0]);
        near_raw  = SH_W'(~frac) >> shift_reg;
        far_raw   = SH_W'(frac) >> shift_reg;

        beat.pixel_address = en ? addr_full[ADDR_W-1:0] : '0;
        beat.far_is_below  = x_major_reg;
        beat.near_shade    = (near_raw > SH_W'(255)) ? 8'hFF : near_raw[SHADE_W-1:0];
        beat.far_shade     = (far_raw > SH_W'(255)) ? 8'hFF : far_raw[SHADE_W-1:0];
        beat.write_enable  = en;
        beat.last          = is_last;
    end

    always_comb
    begin
        width_next   = width_reg;
        height_next  = height_reg;
        active_next  = active_reg;
        x_major_next = x_major_reg;
        pos_next     = pos_reg;
        end_next     = end_reg;
        acc_next     = acc_reg;
        slope_next   = slope_reg;
        shift_next   = shift_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        neg_next     = neg_reg;
        out_next     = out_reg;

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BUFFER_WIDTH:  width_next  = cfg_data;
                REG_BUFFER_HEIGHT: height_next = cfg_data;
                default:           ;
            endcase
        end

        if (cmd.load)
        begin
            active_next  = 1'b0;
            shift_next   = in_data.shade_shift;
            x_major_next = x_major_in;
            pos_next     = major_lo;
            end_next     = major_hi;
            acc_next     = {{(ACC_W - COORD_BITS - FRACTION_BITS){minor_start[COORD_BITS-1]}},
                            minor_start, {FRACTION_BITS{1'b0}}};
            divisor_next = x_major_in ? adx : ady;
            rem_next     = REM_W'(x_major_in ? ady : adx);
            quo_next     = '0;
            neg_next     = dx[MAG_W-1] ^ dy[MAG_W-1];
        end

        if (cmd.div_step)
        begin
            rem_next = {rem_sub[REM_W-2:0], 1'b0};
            quo_next = quo_shift;
        end

        if (cmd.div_done)
        begin
            slope_next  = neg_reg ? -slope_pos : slope_pos;
            active_next = 1'b1;
        end

        if (cmd.emit)
        begin
            out_next    = beat;
            acc_next    = acc_reg + ACC_W'(slope_reg);
            pos_next    = pos_plus;
            active_next = !is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= BUFFER_WIDTH_RESET;
            height_reg <= BUFFER_HEIGHT_RESET;
            active_reg <= 1'b0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_major_reg <= x_major_next;
        pos_reg     <= pos_next;
        end_reg     <= end_next;
        acc_reg     <= acc_next;
        slope_reg   <= slope_next;
        shift_reg   <= shift_next;
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        neg_reg     <= neg_next;
        out_reg     <= out_next;
    end

    assign out_data = out_reg;

endmodule

// ===== rtl/antialiased_line_walker_unit.sv =====
// Top level of the anti-aliased line walker: joins controller and datapath.
// Depends on alw_pkg, alw_controller and alw_datapath.
//
// Input channel (in_valid/in_ready/in_data): a start beat (cmd start) loads
// two endpoints and a shade shift; a step beat (cmd step) emits the next
// pixel pair of the active line. Output channel (out_valid/out_ready/out_data)
// carries one beat per step taken while a line is active: near pixel address,
// far pixel direction, both shades, clip write enable and a last flag.
// Steps while no line is active and start beats produce no output beat.
// A step beat is accepted every cycle while no divide runs and the output
// register is empty or being taken; its output beat is registered and valid
// in the next cycle. A start beat with distinct endpoints runs a restoring
// divider after acceptance, and no beat is accepted until it finishes.
// The single output register lets a new step enter in the same cycle as the
// pending beat is taken; while out_valid is high and out_ready low, in_ready
// stays low. Reset clears the line, the output flag and sets the buffer
// size registers to 384 by 256. cfg_we writes a buffer size register at once.
module antialiased_line_walker_unit
    import alw_pkg::*;
#(
    parameter int FRACTION_BITS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_beat_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_beat_t            out_data
);

    alw_cmd_t    cmd;
    alw_status_t status;

    alw_controller #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_cmd    (in_data.cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    alw_datapath #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

// ===== rtl/alw_checker.sv =====
// Port-level checker for the line walker, bound to the top level.
// Depends on alw_pkg and antialiased_line_walker_unit.
module alw_checker
    import alw_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input in_beat_t  in_data,
    input logic      out_valid,
    input logic      out_ready,
    input out_beat_t out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("Output beat changed while stalled.");

    a_rise_after_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_data.cmd == CMD_STEP))
        else $error("Output beat appeared without an accepted step.");

    a_start_no_beat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.cmd == CMD_START && (!out_valid || out_ready)
        |=> !out_valid)
        else $error("Start beat produced an output beat.");

    a_clip_address: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.write_enable |-> out_data.pixel_address == '0)
        else $error("Clipped pixel carries a nonzero address.");

endmodule

bind antialiased_line_walker_unit alw_checker u_alw_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== verif/tb_antialiased_line_walker_unit.sv =====
`timescale 1ns / 100ps
// Testbench for antialiased_line_walker_unit: start and step beats with random idling on both
// channels, a self-contained line walker predictor and a field-by-field check of each pixel beat.
// Depends on alw_pkg and the block's RTL only.
module tb_antialiased_line_walker_unit;
    import alw_pkg::*;

    localparam int FRAC           = 8;
    localparam int SETTLE_CYCLES  = FRAC + 12;
    localparam int HOLD_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        in_beat_t  beat;
        bit        fixed;
        bit        fixed_has;
        out_beat_t fixed_px;
    } script_row_t;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0]     cfg_data  = '0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_beat_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_beat_t            out_data;

    bit                           line_on    = 1'b0;
    bit                           x_major    = 1'b0;
    logic signed [COORD_BITS-1:0] major_pos  = '0;
    logic signed [COORD_BITS-1:0] major_stop = '0;
    logic signed [23:0]           minor_acc  = '0;
    logic signed [9:0]            minor_step = '0;
    logic [3:0]                   shade_sh   = '0;
    logic [DIM_W-1:0]             buf_w      = BUFFER_WIDTH_RESET;
    logic [DIM_W-1:0]             buf_h      = BUFFER_HEIGHT_RESET;

    out_beat_t   pixel_q[$];
    script_row_t script[$];
    int          mismatch_count = 0;
    int          idle_cycles    = 0;
    int          items_done     = 0;
    bit          no_idle        = 1'b0;
    bit          hold_req       = 1'b0;

    antialiased_line_walker_unit #(
        .FRACTION_BITS(FRAC)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic bit walk_beat(input in_beat_t b, output out_beat_t px);
        int          x1, y1, x2, y2, dx, dy, minor, row, col, w, h;
        int unsigned frac;
        bit          en;
        px = '0;
        if (b.cmd == CMD_START)
        begin
            x1 = $signed(b.start_x);
            y1 = $signed(b.start_y);
            x2 = $signed(b.end_x);
            y2 = $signed(b.end_y);
            dx = x2 - x1;
            dy = y2 - y1;
            shade_sh = b.shade_shift;
            if (dx == 0 && dy == 0)
            begin
                line_on = 1'b0;
                return 1'b0;
            end
            if ((dy < 0 ? -dy : dy) < (dx < 0 ? -dx : dx))
            begin
                x_major = 1'b1;
                if (x1 > x2)
                begin
                    major_pos  = COORD_BITS'(x2);
                    major_stop = COORD_BITS'(x1);
                    y1 = y2;
                end
                else
                begin
                    major_pos  = COORD_BITS'(x1);
                    major_stop = COORD_BITS'(x2);
                end
                minor_step = 10'((dy * (1 << FRAC)) / dx);
                minor_acc  = 24'(y1 * (1 << FRAC));
            end
            else
            begin
                x_major = 1'b0;
                if (y1 > y2)
                begin
                    major_pos  = COORD_BITS'(y2);
                    major_stop = COORD_BITS'(y1);
                    x1 = x2;
                end
                else
                begin
                    major_pos  = COORD_BITS'(y1);
                    major_stop = COORD_BITS'(y2);
                end
                minor_step = 10'((dx * (1 << FRAC)) / dy);
                minor_acc  = 24'(x1 * (1 << FRAC));
            end
            line_on = major_pos < major_stop;
            return 1'b0;
        end
        if (!line_on)
            return 1'b0;
        minor = minor_acc >>> FRAC;
        frac  = minor_acc[FRAC-1:0];
        w     = buf_w;
        h     = buf_h;
        if (x_major)
        begin
            col = major_pos;
            row = minor;
            en  = col >= 0 && col < w && row >= 0 && row < h - 1;
        end
        else
        begin
            row = major_pos;
            col = minor;
            en  = row >= 0 && row < h && col >= 0 && col < w - 1;
        end
        px.pixel_address = en ? ADDR_W'(row * w + col) : '0;
        px.far_is_below  = x_major;
        px.near_shade    = SHADE_W'(((1 << FRAC) - 1 - frac) >> shade_sh);
        px.far_shade     = SHADE_W'(frac >> shade_sh);
        px.write_enable  = en;
        px.last          = (major_pos + 1 == major_stop);
        minor_acc = minor_acc + minor_step;
        major_pos = major_pos + 1;
        if (major_pos >= major_stop)
            line_on = 1'b0;
        return 1'b1;
    endfunction

    function automatic in_beat_t random_beat(input logic cmd);
        in_beat_t r;
        r.cmd         = cmd;
        r.start_x     = COORD_BITS'($urandom);
        r.start_y     = COORD_BITS'($urandom);
        r.end_x       = COORD_BITS'($urandom);
        r.end_y       = COORD_BITS'($urandom);
        r.shade_shift = 4'($urandom);
        return r;
    endfunction

    function automatic script_row_t start_row(input int x1, y1, x2, y2, sh);
        script_row_t r;
        r.beat             = '0;
        r.beat.cmd         = CMD_START;
        r.beat.start_x     = COORD_BITS'(x1);
        r.beat.start_y     = COORD_BITS'(y1);
        r.beat.end_x       = COORD_BITS'(x2);
        r.beat.end_y       = COORD_BITS'(y2);
        r.beat.shade_shift = 4'(sh);
        r.fixed            = 1'b0;
        r.fixed_has        = 1'b0;
        r.fixed_px         = '0;
        return r;
    endfunction

    function automatic script_row_t step_row();
        script_row_t r;
        r.beat      = '0;
        r.beat.cmd  = CMD_STEP;
        r.fixed     = 1'b0;
        r.fixed_has = 1'b0;
        r.fixed_px  = '0;
        return r;
    endfunction

    function automatic script_row_t fixed_step(input bit has, input int addr, below, near, far,
                                               we, lst);
        script_row_t r;
        r = step_row();
        r.fixed                  = 1'b1;
        r.fixed_has              = has;
        r.fixed_px.pixel_address = ADDR_W'(addr);
        r.fixed_px.far_is_below  = 1'(below);
        r.fixed_px.near_shade    = SHADE_W'(near);
        r.fixed_px.far_shade     = SHADE_W'(far);
        r.fixed_px.write_enable  = 1'(we);
        r.fixed_px.last          = 1'(lst);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("Mismatch in %s at %0t: got %0d, expected %0d", what, $time, got, want);
    endtask

    task automatic send_beat(input in_beat_t b, input bit fixed, input bit fixed_has,
                             input out_beat_t fixed_px);
        int        gap;
        bit        has;
        out_beat_t px;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        has = walk_beat(b, px);
        if (b.cmd == CMD_START || has)
            items_done++;
        if (fixed)
        begin
            has = fixed_has;
            px  = fixed_px;
        end
        if (has)
            pixel_q.push_back(px);
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_buffer_size(input int w, input int h);
        drain_outputs();
        cfg_we    <= 1'b1;
        cfg_index <= REG_BUFFER_WIDTH;
        cfg_data  <= DIM_W'(w);
        buf_w = DIM_W'(w);
        @(posedge clk);
        cfg_index <= REG_BUFFER_HEIGHT;
        cfg_data  <= DIM_W'(h);
        buf_h = DIM_W'(h);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_random_lines(input int budget);
        int       stop_at, bx, by, dx, dy, n, steps;
        in_beat_t b;
        stop_at = items_done + budget;
        while (items_done < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_beat(random_beat(1'($urandom_range(0, 1))), 1'b0, 1'b0, '0);
            end
            else
            begin
                b = random_beat(CMD_START);
                if ($urandom_range(0, 4) == 0)
                begin
                    steps = $urandom_range(1, 12);
                end
                else
                begin
                    bx = $urandom_range(0, buf_w + 16) - 8;
                    by = $urandom_range(0, buf_h + 16) - 8;
                    dx = $urandom_range(0, 24) - 12;
                    dy = $urandom_range(0, 24) - 12;
                    b.start_x = COORD_BITS'(bx);
                    b.start_y = COORD_BITS'(by);
                    b.end_x   = COORD_BITS'(bx + dx);
                    b.end_y   = COORD_BITS'(by + dy);
                    dx = dx < 0 ? -dx : dx;
                    dy = dy < 0 ? -dy : dy;
                    n  = dx > dy ? dx : dy;
                    steps = ($urandom_range(0, 5) == 0) ? $urandom_range(0, n)
                                                        : n + $urandom_range(0, 2);
                end
                b.shade_shift = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                            : 4'($urandom_range(0, FRAC));
                send_beat(b, 1'b0, 1'b0, '0);
                repeat (steps) send_beat(random_beat(CMD_STEP), 1'b0, 1'b0, '0);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : receiver
        int        stall;
        out_beat_t want;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                stall    = HOLD_CYCLES;
                hold_req = 1'b0;
            end
            else
            begin
                stall = no_idle ? 0 : $urandom_range(0, 3);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            if (pixel_q.size() == 0)
            begin
                report_mismatch("beat with no pixel pending", out_data.pixel_address, 0);
            end
            else
            begin
                want = pixel_q.pop_front();
                if (out_data.pixel_address !== want.pixel_address)
                    report_mismatch("pixel_address", out_data.pixel_address,
                                    want.pixel_address);
                if (out_data.far_is_below !== want.far_is_below)
                    report_mismatch("far_is_below", out_data.far_is_below, want.far_is_below);
                if (out_data.near_shade !== want.near_shade)
                    report_mismatch("near_shade", out_data.near_shade, want.near_shade);
                if (out_data.far_shade !== want.far_shade)
                    report_mismatch("far_shade", out_data.far_shade, want.far_shade);
                if (out_data.write_enable !== want.write_enable)
                    report_mismatch("write_enable", out_data.write_enable, want.write_enable);
                if (out_data.last !== want.last)
                    report_mismatch("last", out_data.last, want.last);
            end
        end
    end

    initial
    begin : stimulus
        script.push_back(fixed_step(1'b0, 0, 0, 0, 0, 0, 0));
        script.push_back(start_row(0, 0, 4, 1, 0));
        script.push_back(fixed_step(1'b1, 0, 1, 255, 0, 1, 0));
        script.push_back(step_row());
        script.push_back(step_row());
        script.push_back(step_row());
        script.push_back(fixed_step(1'b0, 0, 0, 0, 0, 0, 0));
        script.push_back(start_row(5, 5, 5, 5, 0));
        script.push_back(fixed_step(1'b0, 0, 0, 0, 0, 0, 0));
        script.push_back(start_row(0, 0, 3, 3, 1));
        script.push_back(fixed_step(1'b1, 0, 0, 127, 0, 1, 0));
        script.push_back(step_row());
        script.push_back(start_row(10, 17, 2, 20, 0));
        script.push_back(step_row());
        script.push_back(step_row());
        script.push_back(start_row(-3, -3, -1, -3, 0));
        script.push_back(fixed_step(1'b1, 0, 1, 255, 0, 0, 0));
        script.push_back(fixed_step(1'b1, 0, 1, 255, 0, 0, 1));
        script.push_back(start_row(100, 0, 103, 1, 15));
        script.push_back(fixed_step(1'b1, 100, 1, 0, 0, 1, 0));
        script.push_back(start_row(-2048, -2048, 2047, 2047, 8));
        script.push_back(fixed_step(1'b1, 0, 0, 0, 0, 0, 0));
        script.push_back(start_row(382, 254, 385, 254, 0));
        script.push_back(step_row());
        script.push_back(step_row());
        script.push_back(step_row());

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            send_beat(script[i].beat, script[i].fixed, script[i].fixed_has, script[i].fixed_px);

        // The receiver holds off early in this line so the block backs up into its input.
        no_idle = 1'b1;
        send_beat(start_row(0, 0, 30, 5, 2).beat, 1'b0, 1'b0, '0);
        hold_req = 1'b1;
        repeat (30) send_beat(random_beat(CMD_STEP), 1'b0, 1'b0, '0);
        no_idle = 1'b0;

        set_buffer_size(16, 16);
        send_random_lines(110);
        set_buffer_size(1024, 1024);
        no_idle = 1'b1;
        send_random_lines(110);
        no_idle = 1'b0;
        set_buffer_size(1024, 16);
        send_random_lines(110);
        set_buffer_size(16, 1024);
        send_random_lines(110);
        set_buffer_size($urandom_range(16, 1024), $urandom_range(16, 1024));
        send_random_lines(110);

        drain_outputs();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
